/* design/mbd_pkg.sv */
// Package for the multi-button debouncer: payload words, phase codes,
// controller/datapath command and status structs, register map constants.
// No dependencies.
package mbd_pkg;

  // Input field widths fixed by the payload format
  localparam int unsigned InBits   = 6;
  localparam int unsigned IdxBits  = 3;
  localparam int unsigned CountW   = 8;

  // Register map
  localparam int unsigned PaddrW   = 3;
  localparam logic [0:0]  RegSampleCount = 1'b0;
  localparam logic [CountW-1:0] DefaultSampleCount = 8'd10;

  // Per-button debounce phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_BOUNCING = 2'd1,
    PH_CHANGED  = 2'd2
  } phase_e;

  // Input word
  typedef struct packed {
    logic [InBits-1:0] edge_flags;
    logic [InBits-1:0] raw_levels;
    logic              sample_due;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [IdxBits-1:0] button_index;
    logic               pressed;
    logic               last;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // apply the accepted word to all buttons
    logic step;   // advance the scan index
    logic emit;   // load the result register from the current button
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pending_any;  // some event still to report
    logic pending_hit;  // current scan button has an event
  } dp_sts_t;

endpackage

/* design/mbd_dp.sv */
// Datapath of the multi-button debouncer: per-button debounce state,
// pending event mask, scan index and result register. Uses mbd_pkg.
module mbd_dp #(
  parameter int unsigned NUM_BUTTONS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbd_pkg::dp_cmd_t              cmd_i,
  output mbd_pkg::dp_sts_t              sts_o,
  input  mbd_pkg::in_word_t             in_data_i,
  input  logic [mbd_pkg::CountW-1:0]    sample_count_i,
  output mbd_pkg::out_word_t            out_data_o
);

  localparam int unsigned IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  mbd_pkg::phase_e            phase_q [NUM_BUTTONS];
  mbd_pkg::phase_e            phase_d [NUM_BUTTONS];
  logic                       level_q [NUM_BUTTONS];
  logic                       level_d [NUM_BUTTONS];
  logic [mbd_pkg::CountW-1:0] cnt_q   [NUM_BUTTONS];
  logic [mbd_pkg::CountW-1:0] cnt_d   [NUM_BUTTONS];
  logic [mbd_pkg::CountW-1:0] diff_q  [NUM_BUTTONS];
  logic [mbd_pkg::CountW-1:0] diff_d  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]     pending_q, pending_d;
  logic [NUM_BUTTONS-1:0]     pending_left;
  logic [IdxW-1:0]            idx_q, idx_d;
  mbd_pkg::out_word_t         out_q, out_d;
  logic [NUM_BUTTONS-1:0]     edges, levels;

  // Buttons past the input width read zero; input bits past the count drop
  assign edges  = NUM_BUTTONS'(in_data_i.edge_flags);
  assign levels = NUM_BUTTONS'(in_data_i.raw_levels);

  // Pending mask with the current button removed
  always_comb begin
    pending_left        = pending_q;
    pending_left[idx_q] = 1'b0;
  end

  // Per-button update, all buttons side by side
  always_comb begin
    pending_d = pending_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      phase_d[i] = phase_q[i];
      level_d[i] = level_q[i];
      cnt_d[i]   = cnt_q[i];
      diff_d[i]  = diff_q[i];
      if (cmd_i.load) begin
        pending_d[i] = (phase_q[i] == mbd_pkg::PH_CHANGED);
        if (edges[i] && phase_q[i] == mbd_pkg::PH_IDLE) begin
          phase_d[i] = mbd_pkg::PH_BOUNCING;
        end
        if (phase_d[i] == mbd_pkg::PH_BOUNCING && in_data_i.sample_due) begin
          cnt_d[i] = cnt_q[i] + 8'd1;
          if (levels[i] != level_q[i]) begin
            diff_d[i] = diff_q[i] + 8'd1;
          end
          // window complete: decide
          if (cnt_d[i] >= sample_count_i) begin
            if (diff_d[i] == '0) begin
              phase_d[i] = mbd_pkg::PH_IDLE;
            end else if (diff_d[i] == cnt_d[i]) begin
              level_d[i] = levels[i];
              phase_d[i] = mbd_pkg::PH_CHANGED;
            end
            cnt_d[i]  = '0;
            diff_d[i] = '0;
          end
        end else if (phase_q[i] == mbd_pkg::PH_CHANGED) begin
          phase_d[i] = mbd_pkg::PH_IDLE;
        end
      end
    end
    if (cmd_i.emit) begin
      pending_d = pending_left;
    end
  end

  // Scan index and result word
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
    end
    out_d = out_q;
    if (cmd_i.emit) begin
      out_d.button_index = mbd_pkg::IdxBits'(idx_q);
      out_d.pressed      = ~level_q[idx_q];
      out_d.last         = (pending_left == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_q[i] <= mbd_pkg::PH_IDLE;
        level_q[i] <= 1'b1;
        cnt_q[i]   <= '0;
        diff_q[i]  <= '0;
      end
      pending_q <= '0;
      idx_q     <= '0;
    end else begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_q[i] <= phase_d[i];
        level_q[i] <= level_d[i];
        cnt_q[i]   <= cnt_d[i];
        diff_q[i]  <= diff_d[i];
      end
      pending_q <= pending_d;
      idx_q     <= idx_d;
    end
  end

  // Result word has no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.pending_any = (pending_q != '0);
  assign sts_o.pending_hit = pending_q[idx_q];
  assign out_data_o        = out_q;

endmodule

/* design/mbd_ctrl.sv */
// Controller of the multi-button debouncer: accept, scan and emit sequencing.
// Uses mbd_pkg; drives mbd_dp through command/status structs.
module mbd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mbd_pkg::dp_cmd_t cmd_o,
  input  mbd_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.pending_any) begin
          state_d = ST_IDLE;
        end else if (sts_i.pending_hit) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          cmd_o.step = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  // Checks
  a_load_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_SCAN)
    else $error("accepted word did not start a scan");

  a_emit_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (sts_i.pending_hit && sts_i.pending_any))
    else $error("emit without a pending event");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_ready_i) |=> state_q == ST_EMIT)
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && (cmd_o.emit || cmd_o.step)))
    else $error("load overlaps scan command");

endmodule

/* design/multi_button_debouncer.sv */
// Multi-button debouncer top level: APB register, controller and datapath.
// Uses mbd_pkg, mbd_ctrl and mbd_dp.
//
// Usage: each input word carries per-button edge flags, raw pin levels and
// a common sample_due tick. Every button runs a debounce window of
// sample_count samples (APB register at address 0, reset 10). A button whose
// window came out all-different is reported in the following input word as
// one result word: its index, pressed (new level low) and last on the final
// event of that input word. Events come in ascending button order.
// Timing: a word is taken when in_ready_o is high (only between words). All
// buttons update in the accept cycle; the scan then walks one button per
// cycle while no event waits, holds each event in the result register until
// the receiver takes it, and ends once no event is pending.
// When the receiver stalls, the result word holds and the scan waits.
// Reset: every button idle, level high, counts zero, sample_count 10.
module multi_button_debouncer #(
  parameter int unsigned NUM_BUTTONS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mbd_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mbd_pkg::out_word_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbd_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [mbd_pkg::CountW-1:0] sample_count_q, sample_count_d;
  logic                       reg_sel;
  mbd_pkg::dp_cmd_t           cmd;
  mbd_pkg::dp_sts_t           sts;

  // Register decode on the word index
  assign reg_sel = (paddr[2] == mbd_pkg::RegSampleCount);
  assign pready  = 1'b1;

  always_comb begin
    sample_count_d = sample_count_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      sample_count_d = pwdata[mbd_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= mbd_pkg::DefaultSampleCount;
    end else begin
      sample_count_q <= sample_count_d;
    end
  end

  assign prdata = reg_sel ? 32'(sample_count_q) : 32'd0;

  mbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mbd_dp #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_data_i      (in_data_i),
    .sample_count_i (sample_count_q),
    .out_data_o     (out_data_o)
  );

endmodule

/* verif/tb_multi_button_debouncer.sv */
// Testbench for multi_button_debouncer: directed and random words with a
// per-button debounce predictor inside a small checking class.
// Depends on mbd_pkg and the multi_button_debouncer RTL.
module tb_multi_button_debouncer;

  localparam int NumButtons  = 6;
  localparam int DrainCycles = 20;      // wait after the last event, with margin
  localparam int HoldCycles  = 300;     // long receiver stall
  localparam int CycleLimit  = 300000;
  localparam logic [mbd_pkg::PaddrW-1:0] SampleCountAddr =
    mbd_pkg::PaddrW'(4 * mbd_pkg::RegSampleCount);
  localparam logic [mbd_pkg::PaddrW-1:0] UnmappedAddr = mbd_pkg::PaddrW'(4);

  // Tracks every button's debounce state and the events still to come out
  class button_tracker;
    mbd_pkg::phase_e    phase    [NumButtons];
    logic               level    [NumButtons];
    logic [7:0]         samp_cnt [NumButtons];
    logic [7:0]         diff_cnt [NumButtons];
    logic [7:0]         window_len;
    mbd_pkg::out_word_t reports_due[$];
    int                 mismatches;

    function new();
      window_len = mbd_pkg::DefaultSampleCount;
      mismatches = 0;
      for (int i = 0; i < NumButtons; i++) begin
        phase[i]    = mbd_pkg::PH_IDLE;
        level[i]    = 1'b1;
        samp_cnt[i] = '0;
        diff_cnt[i] = '0;
      end
    endfunction

    // Apply one accepted word and queue the events it causes
    function void note_word(mbd_pkg::in_word_t w);
      mbd_pkg::out_word_t batch [NumButtons];
      int                 n;
      n = 0;
      // edges first, only idle buttons start bouncing
      for (int i = 0; i < NumButtons; i++) begin
        if (w.edge_flags[i] && phase[i] == mbd_pkg::PH_IDLE) phase[i] = mbd_pkg::PH_BOUNCING;
      end
      // scan in ascending order
      for (int i = 0; i < NumButtons; i++) begin
        if (phase[i] == mbd_pkg::PH_BOUNCING && w.sample_due) begin
          samp_cnt[i] = samp_cnt[i] + 8'd1;
          if (w.raw_levels[i] != level[i]) diff_cnt[i] = diff_cnt[i] + 8'd1;
          if (samp_cnt[i] >= window_len) begin
            if (diff_cnt[i] == 8'd0) begin
              phase[i] = mbd_pkg::PH_IDLE;
            end else if (diff_cnt[i] == samp_cnt[i]) begin
              level[i] = w.raw_levels[i];
              phase[i] = mbd_pkg::PH_CHANGED;
            end
            samp_cnt[i] = '0;
            diff_cnt[i] = '0;
          end
        end else if (phase[i] == mbd_pkg::PH_CHANGED) begin
          batch[n].button_index = mbd_pkg::IdxBits'(i);
          batch[n].pressed      = ~level[i];
          batch[n].last         = 1'b0;
          n++;
          phase[i] = mbd_pkg::PH_IDLE;
        end
      end
      for (int k = 0; k < n; k++) begin
        if (k == n - 1) batch[k].last = 1'b1;
        reports_due.push_back(batch[k]);
      end
    endfunction

    // Compare one accepted result word with the oldest expected event
    function void check_report(mbd_pkg::out_word_t got);
      mbd_pkg::out_word_t exp_w;
      if (reports_due.size() == 0) begin
        $error("unexpected result word: button_index %0d pressed %0b last %0b",
               got.button_index, got.pressed, got.last);
        mismatches++;
        return;
      end
      exp_w = reports_due.pop_front();
      if (got.button_index !== exp_w.button_index) begin
        $error("button_index: expected %0d, actual %0d", exp_w.button_index,
               got.button_index);
        mismatches++;
      end
      if (got.pressed !== exp_w.pressed) begin
        $error("pressed: expected %0b, actual %0b", exp_w.pressed, got.pressed);
        mismatches++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0b, actual %0b", exp_w.last, got.last);
        mismatches++;
      end
    endfunction

    function logic [mbd_pkg::InBits-1:0] stored_levels();
      logic [mbd_pkg::InBits-1:0] v;
      for (int i = 0; i < NumButtons; i++) v[i] = level[i];
      return v;
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  mbd_pkg::in_word_t          in_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  mbd_pkg::out_word_t         out_data_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mbd_pkg::PaddrW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  button_tracker tracker;
  bit            tx_quiet;
  bit            rx_quiet;
  bit            hold_req;
  int            cycle_count = 0;

  multi_button_debouncer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_report(out_data_o);
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
      end else if (rx_quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 26);
      end
    end
  end

  // One APB transfer; psel and penable drop after it
  task automatic apb_xfer(input logic wr, input logic [mbd_pkg::PaddrW-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_sample_count();
    logic [31:0] rd;
    apb_xfer(1'b0, SampleCountAddr, '0, rd);
    if (rd !== {24'd0, tracker.window_len}) begin
      $error("prdata: expected %0d, actual %0d", tracker.window_len, rd);
      tracker.mismatches++;
    end
  endtask

  task automatic set_sample_count(input logic [7:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, SampleCountAddr, {24'd0, val}, rd);
    tracker.window_len = val;
    check_sample_count();
  endtask

  // Send one word, with a random gap ahead of it
  task automatic send_word(input mbd_pkg::in_word_t w);
    int gap;
    gap = 0;
    if (!tx_quiet) while ($urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_word(w);
  endtask

  // Idle the sender until every expected event came out and the scan is done
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic mbd_pkg::in_word_t mk_word(logic [mbd_pkg::InBits-1:0] e,
                                                logic [mbd_pkg::InBits-1:0] l,
                                                logic d);
    mbd_pkg::in_word_t w;
    w.edge_flags = e;
    w.raw_levels = l;
    w.sample_due = d;
    return w;
  endfunction

  // Edge, one full window of samples against the stored level, then a word
  // that lets the changed buttons report; glitches break the window
  task automatic run_sequence(input logic [mbd_pkg::InBits-1:0] mask,
                              input int glitch_pct);
    int                         win;
    logic [mbd_pkg::InBits-1:0] lv;
    win = (tracker.window_len == 8'd0) ? 1 : int'(tracker.window_len);
    send_word(mk_word(mask | (mbd_pkg::InBits'($urandom) & mbd_pkg::InBits'($urandom)),
                      mbd_pkg::InBits'($urandom), ($urandom_range(99) < 20)));
    for (int k = 0; k < win; k++) begin
      if ($urandom_range(99) < 10)
        send_word(mk_word(mbd_pkg::InBits'($urandom) & mbd_pkg::InBits'($urandom),
                          mbd_pkg::InBits'($urandom), 1'b0));
      lv = (mbd_pkg::InBits'($urandom) & ~mask) | (~tracker.stored_levels() & mask);
      if ($urandom_range(99) < glitch_pct) lv[$urandom_range(NumButtons - 1)] ^= 1'b1;
      send_word(mk_word(mbd_pkg::InBits'($urandom) & mbd_pkg::InBits'($urandom) &
                        mbd_pkg::InBits'($urandom), lv, 1'b1));
    end
    send_word(mk_word(mbd_pkg::InBits'($urandom), mbd_pkg::InBits'($urandom),
                      1'($urandom_range(1))));
  endtask

  // Mostly well-formed sequences, the rest plain noise words
  task automatic run_traffic(input int n_words);
    int done_words;
    done_words = 0;
    while (done_words < n_words) begin
      if ($urandom_range(99) < 70) begin
        run_sequence(mbd_pkg::InBits'($urandom_range(1, 63)), 15);
        done_words += int'(tracker.window_len) + 2;
      end else begin
        send_word(mk_word(mbd_pkg::InBits'($urandom), mbd_pkg::InBits'($urandom),
                          1'($urandom_range(1))));
        done_words++;
      end
    end
  endtask

  initial begin
    logic [31:0] rd;
    tracker     = new();
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset value, then one-sample windows
    check_sample_count();
    set_sample_count(8'd1);
    send_word(mk_word(6'h00, 6'h00, 1'b0));
    send_word(mk_word(6'h3F, 6'h00, 1'b0));   // all bounce, no sample tick
    send_word(mk_word(6'h3F, 6'h00, 1'b1));   // edges ignored, all change low
    send_word(mk_word(6'h3F, 6'h3F, 1'b1));   // six presses, changed skips sampling
    send_word(mk_word(6'h3F, 6'h3F, 1'b1));   // all change high
    send_word(mk_word(6'h00, 6'h00, 1'b0));   // six releases
    send_word(mk_word(6'h15, 6'h2A, 1'b1));
    send_word(mk_word(6'h00, 6'h3F, 1'b0));   // presses on 0, 2, 4
    send_word(mk_word(6'h2A, 6'h3F, 1'b1));   // all same level: back to idle
    wait_drained();

    // Directed: zero-length window acts as one sample
    set_sample_count(8'd0);
    send_word(mk_word(6'h01, 6'h3E, 1'b1));
    send_word(mk_word(6'h01, 6'h01, 1'b1));
    send_word(mk_word(6'h00, 6'h00, 1'b0));
    wait_drained();

    // Unmapped register write leaves sample_count alone
    apb_xfer(1'b1, UnmappedAddr, 32'hFF, rd);
    check_sample_count();
    send_word(mk_word(6'h20, 6'h00, 1'b1));
    send_word(mk_word(6'h00, 6'h00, 1'b0));
    wait_drained();

    // Random with short windows, then a long receiver stall under load
    set_sample_count(8'd3);
    run_traffic(40);
    hold_req = 1'b1;
    run_traffic(20);
    wait_drained();

    // Single-sample windows with no idling on either side
    set_sample_count(8'd1);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_traffic(25);
    wait_drained();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Long window, one clean pass over all buttons
    set_sample_count(8'd24);
    run_sequence(6'h3F, 0);
    wait_drained();

    // Back to the default window length
    set_sample_count(mbd_pkg::DefaultSampleCount);
    run_traffic(12);
    wait_drained();

    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* multi_button_debouncer.f */
design/mbd_pkg.sv
design/mbd_dp.sv
design/mbd_ctrl.sv
design/multi_button_debouncer.sv
verif/tb_multi_button_debouncer.sv
